### design/ttm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_pkg
// shared types, codes and constants of the two-tape turing machine step block
// ----------------------------------------------------------------------------
package ttm_pkg;

    localparam int TAPE_DEPTH = 1024;
    localparam int RULE_SLOTS = 64;
    localparam int ADDR_W     = 10;
    localparam int SLOT_W     = 6;
    localparam int STATE_W    = 6;
    localparam int SYM_W      = 8;
    localparam int MOVE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 32;
    localparam int UPC_W      = 4;
    localparam int UCODE_LEN  = 10;

    localparam logic [SYM_W-1:0]  BLANK_SYM = SYM_W'(95);
    localparam logic [ADDR_W-1:0] HEAD_HOME = ADDR_W'(TAPE_DEPTH / 2);
    localparam logic [ADDR_W-1:0] HEAD_LAST = ADDR_W'(TAPE_DEPTH - 1);

    localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd1;
    localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd2;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CELL = 2'd1;
    localparam logic [1:0] OP_STEP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_LOADED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STEPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NORULE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EDGE = 3'd4;

    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ACCEPT = 1'b1;

    typedef enum logic [1:0] {
        HALT_RUN,
        HALT_ACCEPT,
        HALT_NORULE
    } t_halt;

    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   read_sym0;
        logic [SYM_W-1:0]   read_sym1;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   write_sym0;
        logic [SYM_W-1:0]   write_sym1;
        logic [MOVE_W-1:0]  move0;
        logic [MOVE_W-1:0]  move1;
    } t_rule;

    typedef struct packed {
        logic [SYM_W-1:0]   cell_sym;
        logic [ADDR_W-1:0]  cell_addr;
        logic [MOVE_W-1:0]  move1;
        logic [MOVE_W-1:0]  move0;
        logic [SYM_W-1:0]   write_sym1;
        logic [SYM_W-1:0]   write_sym0;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   read_sym1;
        logic [SYM_W-1:0]   read_sym0;
        logic [STATE_W-1:0] from_state;
        logic [SLOT_W-1:0]  rule_slot;
    } t_item;

    typedef enum logic [3:0] {
        A_NOP,
        A_LOAD,
        A_CELL,
        A_CHECK,
        A_SEARCH,
        A_NORULE,
        A_APPLY,
        A_READ,
        A_EMIT
    } t_act;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_ACCEPT,
        J_OP,
        J_HALT,
        J_SEARCH,
        J_EMIT
    } t_jmp;

    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_IDLE     = 4'd0;
    localparam t_upc U_DISPATCH = 4'd1;
    localparam t_upc U_LOAD     = 4'd2;
    localparam t_upc U_CELL     = 4'd3;
    localparam t_upc U_CHECK    = 4'd4;
    localparam t_upc U_SEARCH   = 4'd5;
    localparam t_upc U_NORULE   = 4'd6;
    localparam t_upc U_APPLY    = 4'd7;
    localparam t_upc U_READ     = 4'd8;
    localparam t_upc U_EMIT     = 4'd9;

    typedef struct packed {
        t_act act;
        t_jmp jmp;
        t_upc target;
    } t_uword;

    typedef struct packed {
        logic       accepted;
        logic [1:0] op;
        logic       halt;
        logic       hit;
        logic       scan_end;
        logic       out_busy;
    } t_cond;

endpackage
`default_nettype wire

### design/ttm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_seq
// microcode rom, step counter and jump logic driving the datapath
// ----------------------------------------------------------------------------
module ttm_seq
    import ttm_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_cond  i_cond,
    output t_uword o_uword
);

    localparam t_uword UCODE [UCODE_LEN] = '{
        '{A_NOP,    J_ACCEPT, U_IDLE},
        '{A_NOP,    J_OP,     U_IDLE},
        '{A_LOAD,   J_GOTO,   U_READ},
        '{A_CELL,   J_GOTO,   U_READ},
        '{A_CHECK,  J_HALT,   U_READ},
        '{A_SEARCH, J_SEARCH, U_APPLY},
        '{A_NORULE, J_GOTO,   U_READ},
        '{A_APPLY,  J_NEXT,   U_IDLE},
        '{A_READ,   J_NEXT,   U_IDLE},
        '{A_EMIT,   J_EMIT,   U_IDLE}
    };

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uword;

    assign w_uword = UCODE[r_upc];
    assign o_uword = w_uword;

    always_comb begin
        n_upc = r_upc;
        unique case (w_uword.jmp)
            J_NEXT:   n_upc = r_upc + 1'b1;
            J_GOTO:   n_upc = w_uword.target;
            J_ACCEPT: n_upc = i_cond.accepted ? r_upc + 1'b1 : r_upc;
            J_OP: begin
                unique case (i_cond.op)
                    OP_LOAD: n_upc = U_LOAD;
                    OP_CELL: n_upc = U_CELL;
                    OP_STEP: n_upc = U_CHECK;
                    default: n_upc = U_READ;
                endcase
            end
            J_HALT:   n_upc = i_cond.halt ? w_uword.target : r_upc + 1'b1;
            J_SEARCH: begin
                if (i_cond.hit) begin
                    n_upc = w_uword.target;
                end else if (i_cond.scan_end) begin
                    n_upc = r_upc + 1'b1;
                end
            end
            J_EMIT:   n_upc = i_cond.out_busy ? r_upc : w_uword.target;
            default:  n_upc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule
`default_nettype wire

### design/ttm_rule_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_rule_mem
// rule store with per-slot valid bits and a registered read port
// ----------------------------------------------------------------------------
module ttm_rule_mem
    import ttm_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_we,
    input  wire  [SLOT_W-1:0] i_wa,
    input  t_rule             i_wd,
    input  wire               i_re,
    input  wire  [SLOT_W-1:0] i_ra,
    output t_rule             o_q,
    output logic              o_qv
);

    t_rule                 mem [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] r_valid;
    t_rule                 r_q;
    logic                  r_qv;

    assign o_q  = r_q;
    assign o_qv = r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_q <= mem[i_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_wa] <= 1'b1;
            end
            if (i_re) begin
                r_qv <= r_valid[i_ra];
            end
        end
    end

endmodule
`default_nettype wire

### design/ttm_tape_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_tape_mem
// one tape: single write port, registered read port
// ----------------------------------------------------------------------------
module ttm_tape_mem
    import ttm_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_we,
    input  wire  [ADDR_W-1:0] i_wa,
    input  wire  [SYM_W-1:0]  i_wd,
    input  wire               i_re,
    input  wire  [ADDR_W-1:0] i_ra,
    output logic [SYM_W-1:0]  o_q
);

    logic [SYM_W-1:0] mem [TAPE_DEPTH];
    logic [SYM_W-1:0] r_q;

    assign o_q = r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
    end

    // read data starts out as the blank under the home cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= BLANK_SYM;
        end else if (i_re) begin
            r_q <= mem[i_ra];
        end
    end

endmodule
`default_nettype wire

### design/two_tape_turing_machine_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_tape_turing_machine_step
// Items arrive on the s channel (op in tuser) and each gives one result beat
// on the m channel (status in tuser). The cfg channel writes start_state
// (index 0) and accept_state (index 1) and is always ready.
// A rule load or a cell write passes dispatch, its write step, the tape read
// and the emit step; an unused op goes from dispatch to the tape read. A step
// skips the rule search if the machine is halted or in the accept state; the
// search reads one rule slot per cycle from the rule store, lowest slot
// first, up to all 64 slots. The next item is taken only once the sequencer
// is back in idle after emitting the last result.
// After reset both tapes are cleared to the blank symbol, one cell of each
// per cycle, and s_tready stays low until all 1024 cells are cleared.
// Results wait in an output register; while the receiver stalls, one more
// item is taken and worked through, then the block holds at its last step
// and takes nothing further until the waiting beat is delivered.
// ----------------------------------------------------------------------------
module two_tape_turing_machine_step
    import ttm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // rule_slot, from_state, read_sym0, read_sym1, to_state, write_sym0,
    // write_sym1, move0, move1, cell_addr, cell_sym
    input  wire  [71:0] i_s_tdata,
    // op
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // machine_state, sym_under_head0, sym_under_head1, head0_pos, head1_pos,
    // step_count, zero pad
    output logic [79:0] o_m_tdata,
    // status
    output logic [2:0]  o_m_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [5:0]  i_cfg_data
);

    localparam int OUT_W = STATE_W + 2 * SYM_W + 2 * ADDR_W + COUNT_W;

    t_uword w_uw;
    t_cond  w_cond;

    t_item                r_item;
    logic [1:0]           r_op;
    logic [STATE_W-1:0]   r_state;
    logic [STATE_W-1:0]   r_accept;
    logic [ADDR_W-1:0]    r_head0;
    logic [ADDR_W-1:0]    r_head1;
    logic [COUNT_W-1:0]   r_count;
    t_halt                r_halt;
    logic [STATUS_W-1:0]  r_status;
    logic [SLOT_W:0]      r_scan;
    logic                 r_chk;
    logic [ADDR_W:0]      r_clr;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;
    logic [STATUS_W-1:0]  r_m_status;

    logic                 w_clearing;
    logic                 w_accepted;
    logic                 w_cfg_wr;
    logic                 w_hit;
    logic                 w_issue;
    t_rule                w_rule_wd;
    t_rule                w_rule_q;
    logic                 w_rule_qv;
    logic                 w_t0_we;
    logic                 w_t1_we;
    logic [ADDR_W-1:0]    w_t0_wa;
    logic [ADDR_W-1:0]    w_t1_wa;
    logic [SYM_W-1:0]     w_t0_wd;
    logic [SYM_W-1:0]     w_t1_wd;
    logic [SYM_W-1:0]     w_t0_q;
    logic [SYM_W-1:0]     w_t1_q;
    logic                 w_rd;
    logic [ADDR_W:0]      w_mv0;
    logic [ADDR_W:0]      w_mv1;

    // returns {refused at edge, new position}
    function automatic logic [ADDR_W:0] f_move(input logic [ADDR_W-1:0] pos,
                                               input logic [MOVE_W-1:0] mv);
        logic [ADDR_W:0] res;
        res = {1'b0, pos};
        if (mv == MV_RIGHT) begin
            if (pos == HEAD_LAST) begin
                res[ADDR_W] = 1'b1;
            end else begin
                res[ADDR_W-1:0] = pos + 1'b1;
            end
        end else if (mv == MV_LEFT) begin
            if (pos == '0) begin
                res[ADDR_W] = 1'b1;
            end else begin
                res[ADDR_W-1:0] = pos - 1'b1;
            end
        end
        return res;
    endfunction

    assign w_clearing  = !r_clr[ADDR_W];
    assign o_s_tready  = (w_uw.jmp == J_ACCEPT) && !w_clearing;
    assign w_accepted  = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    assign w_hit = (w_uw.act == A_SEARCH) && r_chk && w_rule_qv
                   && (w_rule_q.from_state == r_state)
                   && (w_rule_q.read_sym0 == w_t0_q)
                   && (w_rule_q.read_sym1 == w_t1_q);
    assign w_issue = (w_uw.act == A_SEARCH) && !r_scan[SLOT_W] && !w_hit;

    assign w_cond.accepted = w_accepted;
    assign w_cond.op       = r_op;
    assign w_cond.halt     = (r_halt != HALT_RUN) || (r_state == r_accept);
    assign w_cond.hit      = w_hit;
    assign w_cond.scan_end = r_scan[SLOT_W] && !w_hit;
    assign w_cond.out_busy = r_m_valid && !i_m_tready;

    ttm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_uword (w_uw)
    );

    assign w_rule_wd = '{
        from_state: r_item.from_state,
        read_sym0:  r_item.read_sym0,
        read_sym1:  r_item.read_sym1,
        to_state:   r_item.to_state,
        write_sym0: r_item.write_sym0,
        write_sym1: r_item.write_sym1,
        move0:      r_item.move0,
        move1:      r_item.move1
    };

    ttm_rule_mem u_rule_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_uw.act == A_LOAD),
        .i_wa    (r_item.rule_slot),
        .i_wd    (w_rule_wd),
        .i_re    (w_issue),
        .i_ra    (r_scan[SLOT_W-1:0]),
        .o_q     (w_rule_q),
        .o_qv    (w_rule_qv)
    );

    assign w_mv0 = f_move(r_head0, w_rule_q.move0);
    assign w_mv1 = f_move(r_head1, w_rule_q.move1);

    always_comb begin
        w_t0_we = 1'b0;
        w_t1_we = 1'b0;
        w_t0_wa = r_head0;
        w_t1_wa = r_head1;
        w_t0_wd = w_rule_q.write_sym0;
        w_t1_wd = w_rule_q.write_sym1;
        if (w_clearing) begin
            w_t0_we = 1'b1;
            w_t1_we = 1'b1;
            w_t0_wa = r_clr[ADDR_W-1:0];
            w_t1_wa = r_clr[ADDR_W-1:0];
            w_t0_wd = BLANK_SYM;
            w_t1_wd = BLANK_SYM;
        end else if (w_uw.act == A_CELL) begin
            w_t0_we = 1'b1;
            w_t0_wa = r_item.cell_addr;
            w_t0_wd = r_item.cell_sym;
        end else if (w_uw.act == A_APPLY) begin
            w_t0_we = 1'b1;
            w_t1_we = 1'b1;
        end
    end

    assign w_rd = (w_uw.act == A_READ);

    ttm_tape_mem u_tape0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_t0_we),
        .i_wa    (w_t0_wa),
        .i_wd    (w_t0_wd),
        .i_re    (w_rd),
        .i_ra    (r_head0),
        .o_q     (w_t0_q)
    );

    ttm_tape_mem u_tape1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_t1_we),
        .i_wa    (w_t1_wa),
        .i_wd    (w_t1_wd),
        .i_re    (w_rd),
        .i_ra    (r_head1),
        .o_q     (w_t1_q)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_accepted) begin
            r_item <= t_item'(i_s_tdata);
            r_op   <= i_s_tuser;
        end
    end

    // machine state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_accept   <= STATE_W'(1);
            r_head0    <= HEAD_HOME;
            r_head1    <= HEAD_HOME;
            r_count    <= '0;
            r_halt     <= HALT_RUN;
            r_status   <= ST_LOADED;
            r_scan     <= '0;
            r_chk      <= 1'b0;
            r_clr      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (w_clearing) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_accepted) begin
                r_status <= ST_LOADED;
            end
            unique case (w_uw.act)
                A_CHECK: begin
                    r_scan <= '0;
                    r_chk  <= 1'b0;
                    if (r_halt == HALT_ACCEPT) begin
                        r_status <= ST_ACCEPT;
                    end else if (r_halt == HALT_NORULE) begin
                        r_status <= ST_NORULE;
                    end else if (r_state == r_accept) begin
                        r_halt   <= HALT_ACCEPT;
                        r_status <= ST_ACCEPT;
                    end else if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                A_SEARCH: begin
                    r_chk <= w_issue;
                    if (w_issue) begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                A_NORULE: begin
                    r_halt   <= HALT_NORULE;
                    r_status <= ST_NORULE;
                end
                A_APPLY: begin
                    r_state  <= w_rule_q.to_state;
                    r_head0  <= w_mv0[ADDR_W-1:0];
                    r_head1  <= w_mv1[ADDR_W-1:0];
                    r_status <= (w_mv0[ADDR_W] || w_mv1[ADDR_W]) ? ST_EDGE : ST_STEPPED;
                end
                default: begin
                end
            endcase
            if (w_uw.act == A_EMIT && !w_cond.out_busy) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                if (i_cfg_index == CFG_START) begin
                    if (r_count == '0 && r_halt == HALT_RUN) begin
                        r_state <= i_cfg_data;
                    end
                end else begin
                    r_accept <= i_cfg_data;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_uw.act == A_EMIT && !w_cond.out_busy) begin
            r_m_data   <= {r_count, r_head1, r_head0, w_t1_q, w_t0_q, r_state};
            r_m_status <= r_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(80 - OUT_W){1'b0}}, r_m_data};
    assign o_m_tuser  = r_m_status;

endmodule
`default_nettype wire
